>>> design/count_longest_increasing_subseq_macros.svh
// Assertion helpers shared by the RTL files. Clock is clk, reset is rst.
`ifndef COUNT_LONGEST_INCREASING_SUBSEQ_MACROS_SVH
`define COUNT_LONGEST_INCREASING_SUBSEQ_MACROS_SVH
`ifndef SYNTHESIS
`define CLIS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLIS_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CLIS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CLIS_CHECK(lbl, prop, msg)
`define CLIS_CHECK_IMP(lbl, ante, cons, msg)
`define CLIS_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/clis_pkg.sv
`timescale 1ns / 1ps
package clis_pkg;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 64;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int LEN_W   = 7;

  localparam int BKT_AW = $clog2(NUM_BUCKETS);
  localparam int OFF_W  = $clog2(BUCKET_DEPTH);
  localparam int ENT_AW = $clog2(NUM_BUCKETS * BUCKET_DEPTH);
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int USE_W  = $clog2(NUM_BUCKETS + 1);
  localparam int IDX_W  = (FILL_W > USE_W) ? FILL_W : USE_W;

  // per-bucket record: entry count and most recent (smallest) value
  typedef struct packed {
    logic [FILL_W-1:0]         fill;
    logic signed [VALUE_W-1:0] tail;
  } bucket_word_t;

  // per-entry record: value and running prefix sum of path counts
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        prefix;
  } entry_word_t;

  // control from the sequencer to the search unit
  typedef struct packed {
    logic             init;
    logic             step;
    logic             descend;
    logic [IDX_W-1:0] bound;
  } srch_ctl_t;

endpackage

>>> design/clis_if.sv
`timescale 1ns / 1ps
interface clis_in_if;
  import clis_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      start_req;

  modport source (output valid, value, start_req, input ready);
  modport sink   (input valid, value, start_req, output ready);
endinterface

interface clis_out_if;
  import clis_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   lis_length;
  logic [COUNT_W-1:0] lis_count;
  logic               overflow;

  modport source (output valid, lis_length, lis_count, overflow, input ready);
  modport sink   (input valid, lis_length, lis_count, overflow, output ready);
endinterface

>>> design/clis_ram.sv
`timescale 1ns / 1ps
module clis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/clis_search.sv
`timescale 1ns / 1ps
`include "count_longest_increasing_subseq_macros.svh"
module clis_search (
  input  logic                               clk,
  input  logic                               rst,
  input  clis_pkg::srch_ctl_t                ctl,
  input  logic signed [clis_pkg::VALUE_W-1:0] key,
  input  logic signed [clis_pkg::VALUE_W-1:0] probe,
  output logic [clis_pkg::IDX_W-1:0]         mid,
  output logic [clis_pkg::IDX_W-1:0]         lo_out,
  output logic                               done
);
  import clis_pkg::*;

  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic             descend;
  logic             go_right;

  assign mid    = lo + ((hi - lo) >> 1);
  assign lo_out = lo;
  assign done   = !(lo < hi);

  // ascending tails: move right while probe < key
  // descending entries: move right while probe >= key
  assign go_right = (probe < key) ^ descend;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo      <= '0;
      hi      <= '0;
      descend <= 1'b0;
    end else if (ctl.init) begin
      lo      <= '0;
      hi      <= ctl.bound;
      descend <= ctl.descend;
    end else if (ctl.step) begin
      if (go_right) begin
        lo <= mid + IDX_W'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  `CLIS_CHECK(a_srch_order, lo <= hi, "search window inverted")
  `CLIS_CHECK_IMP(a_srch_live, ctl.step, !done, "search step after window closed")
  `CLIS_CHECK_NEXT(a_srch_shrink, ctl.step && !ctl.init, (hi - lo) < $past(hi - lo),
    "search window did not shrink")

endmodule

>>> design/count_longest_increasing_subseq.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                           Handshake
// in_ch     in   value[31:0] signed, start_req     valid/ready
// out_ch    out  lis_length[6:0], lis_count[31:0], valid/ready
//                overflow
//
// One transaction in, one result out. An item runs two binary searches (bucket
// tails, then entries of the previous bucket), up to 7 probes each, each probe
// an address state and a compare state on the registered-read RAMs, plus a few
// prefix-sum reads and a write state.
// Synchronous active-high reset; no clearing pass, bucket fill is re-zeroed
// when a bucket is opened. in_ch.ready is high only between items; a stalled
// out_ch holds the finished item back from the output register.
`include "count_longest_increasing_subseq_macros.svh"
module count_longest_increasing_subseq (
  input logic       clk,
  input logic       rst,
  clis_in_if.sink   in_ch,
  clis_out_if.source out_ch
);
  import clis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_T_ADDR, S_T_CMP, S_F_K, S_F_PREV, S_V_ADDR, S_V_CMP,
    S_R_TOT, S_R_BEF, S_SUM_RD, S_SUM_WAIT, S_WRITE, S_FIN
  } state_t;

  state_t                    state;
  logic signed [VALUE_W-1:0] v;
  logic [USE_W-1:0]          k;
  logic [USE_W-1:0]          km1;
  logic [FILL_W-1:0]         fill_k;
  logic [FILL_W-1:0]         n_prev;
  logic [COUNT_W-1:0]        acc;
  logic [USE_W-1:0]          in_use;
  logic                      overflow_seen;
  logic [COUNT_W-1:0]        lis_count;
  logic                      out_valid;
  logic [LEN_W-1:0]          out_len;
  logic [COUNT_W-1:0]        out_cnt;
  logic                      out_ovf;
  logic                      in_fire;

  logic                      bkt_re, bkt_we;
  logic [BKT_AW-1:0]         bkt_raddr, bkt_waddr;
  bucket_word_t              bkt_wdata, bkt_rd;
  logic                      ent_re, ent_we;
  logic [ENT_AW-1:0]         ent_raddr, ent_waddr;
  entry_word_t               ent_wdata, ent_rd;

  srch_ctl_t                 sctl;
  logic signed [VALUE_W-1:0] probe;
  logic [IDX_W-1:0]          s_mid, s_lo, s_lo_m1;
  logic                      s_done;
  logic                      lo_is_new;

  function automatic logic [ENT_AW-1:0] ent_addr(input logic [BKT_AW-1:0] b,
                                                 input logic [OFF_W-1:0] o);
    return ENT_AW'(b) * ENT_AW'(BUCKET_DEPTH) + ENT_AW'(o);
  endfunction

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign km1       = k - USE_W'(1);
  assign s_lo_m1   = s_lo - IDX_W'(1);
  assign lo_is_new = (s_lo == IDX_W'(in_use));

  assign out_ch.valid      = out_valid;
  assign out_ch.lis_length = out_len;
  assign out_ch.lis_count  = out_cnt;
  assign out_ch.overflow   = out_ovf;

  clis_ram #(.WIDTH($bits(bucket_word_t)), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .re    (bkt_re),
    .raddr (bkt_raddr),
    .rdata (bkt_rd)
  );

  clis_ram #(.WIDTH($bits(entry_word_t)), .DEPTH(NUM_BUCKETS * BUCKET_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  clis_search u_search (
    .clk    (clk),
    .rst    (rst),
    .ctl    (sctl),
    .key    (v),
    .probe  (probe),
    .mid    (s_mid),
    .lo_out (s_lo),
    .done   (s_done)
  );

  always_comb begin
    bkt_re       = 1'b0;
    bkt_raddr    = '0;
    bkt_we       = 1'b0;
    bkt_waddr    = k[BKT_AW-1:0];
    bkt_wdata    = '{fill: fill_k + FILL_W'(1), tail: v};
    ent_re       = 1'b0;
    ent_raddr    = '0;
    ent_we       = 1'b0;
    ent_waddr    = ent_addr(k[BKT_AW-1:0], OFF_W'(fill_k));
    ent_wdata    = '{value: v, prefix: acc};
    sctl         = '0;
    probe        = bkt_rd.tail;
    unique case (state)
      S_IDLE: begin
        sctl.init  = in_fire;
        sctl.bound = in_ch.start_req ? '0 : IDX_W'(in_use);
      end
      S_T_ADDR: begin
        bkt_re = 1'b1;
        if (!s_done) begin
          bkt_raddr = BKT_AW'(s_mid);
        end else if (lo_is_new) begin
          bkt_raddr = BKT_AW'(s_lo_m1);
        end else begin
          bkt_raddr = BKT_AW'(s_lo);
        end
      end
      S_T_CMP: begin
        sctl.step = 1'b1;
        probe     = bkt_rd.tail;
      end
      S_F_K: begin
        bkt_re    = 1'b1;
        bkt_raddr = km1[BKT_AW-1:0];
      end
      S_F_PREV: begin
        sctl.init    = 1'b1;
        sctl.descend = 1'b1;
        sctl.bound   = IDX_W'(bkt_rd.fill);
      end
      S_V_ADDR: begin
        ent_re = 1'b1;
        if (!s_done) begin
          ent_raddr = ent_addr(km1[BKT_AW-1:0], OFF_W'(s_mid));
        end else begin
          ent_raddr = ent_addr(km1[BKT_AW-1:0], OFF_W'(n_prev - FILL_W'(1)));
        end
      end
      S_V_CMP: begin
        sctl.step = 1'b1;
        probe     = ent_rd.value;
      end
      S_R_TOT: begin
        ent_re    = 1'b1;
        ent_raddr = ent_addr(km1[BKT_AW-1:0], OFF_W'(s_lo_m1));
      end
      S_SUM_RD: begin
        ent_re    = 1'b1;
        ent_raddr = ent_addr(k[BKT_AW-1:0], OFF_W'(fill_k - FILL_W'(1)));
      end
      S_WRITE: begin
        bkt_we = 1'b1;
        ent_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_use        <= '0;
      overflow_seen <= 1'b0;
      lis_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      // in S_FIN a consumed result is replaced below
      if (out_ch.valid && out_ch.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            v <= in_ch.value;
            if (in_ch.start_req) begin
              in_use        <= '0;
              overflow_seen <= 1'b0;
              lis_count     <= '0;
            end
            state <= S_T_ADDR;
          end
        end
        S_T_ADDR: begin
          if (!s_done) begin
            state <= S_T_CMP;
          end else begin
            k <= USE_W'(s_lo);
            if (s_lo == IDX_W'(NUM_BUCKETS)) begin
              overflow_seen <= 1'b1;
              state         <= S_FIN;
            end else if (lo_is_new) begin
              // opening a new bucket
              fill_k <= '0;
              if (s_lo == '0) begin
                acc   <= COUNT_W'(1);
                state <= S_SUM_RD;
              end else begin
                state <= S_F_PREV;
              end
            end else begin
              state <= S_F_K;
            end
          end
        end
        S_T_CMP: begin
          state <= S_T_ADDR;
        end
        S_F_K: begin
          fill_k <= bkt_rd.fill;
          if (bkt_rd.fill >= FILL_W'(BUCKET_DEPTH)) begin
            overflow_seen <= 1'b1;
            state         <= S_FIN;
          end else if (k == '0) begin
            acc   <= COUNT_W'(1);
            state <= S_SUM_RD;
          end else begin
            state <= S_F_PREV;
          end
        end
        S_F_PREV: begin
          n_prev <= bkt_rd.fill;
          state  <= S_V_ADDR;
        end
        S_V_ADDR: begin
          state <= s_done ? S_R_TOT : S_V_CMP;
        end
        S_V_CMP: begin
          state <= S_V_ADDR;
        end
        S_R_TOT: begin
          acc   <= ent_rd.prefix;
          state <= (s_lo == '0) ? S_SUM_RD : S_R_BEF;
        end
        S_R_BEF: begin
          acc   <= acc - ent_rd.prefix;
          state <= S_SUM_RD;
        end
        S_SUM_RD: begin
          state <= (fill_k == '0) ? S_WRITE : S_SUM_WAIT;
        end
        S_SUM_WAIT: begin
          acc   <= acc + ent_rd.prefix;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (k == in_use) begin
            in_use    <= in_use + USE_W'(1);
            lis_count <= acc;
          end else if (k == in_use - USE_W'(1)) begin
            lis_count <= acc;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_len   <= LEN_W'(in_use);
            out_cnt   <= lis_count;
            out_ovf   <= overflow_seen;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CLIS_CHECK(a_in_use_bound, in_use <= USE_W'(NUM_BUCKETS), "bucket count beyond limit")
  `CLIS_CHECK_NEXT(a_start_clears, in_fire && in_ch.start_req,
    in_use == '0 && !overflow_seen && lis_count == '0, "start did not clear state")
  `CLIS_CHECK_IMP(a_write_room, ent_we, fill_k < FILL_W'(BUCKET_DEPTH),
    "entry write into a full bucket")

endmodule
